>>> design/ictf_pkg.sv
// Shared types and constants of the IPX client table forwarder.
package ictf_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;
  localparam logic [15:0] ECHO_SOCKET = 16'h0002;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_FWD       = 2'd0,
    KIND_NEW       = 2'd1,
    KIND_RECONNECT = 2'd2
  } kind_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FWD,
    S_FLUSH
  } state_t;

  // One incoming header word.
  typedef struct packed {
    logic [31:0] dest_host;
    logic [15:0] dest_port;
    logic [31:0] src_host;
    logic [15:0] src_port;
    logic [31:0] src_network;
    logic [31:0] dest_network;
    logic [15:0] dest_socket;
    logic [31:0] sender_ip;
    logic [15:0] sender_port;
  } hdr_t;

  // One outgoing result word.
  typedef struct packed {
    kind_t       kind;
    logic [3:0]  slot;
    logic [31:0] client_ip;
    logic [15:0] client_port;
    logic [31:0] assigned_host;
    logic [15:0] assigned_port;
    logic [31:0] client_network;
    logic        last;
  } res_t;

  // Contents of one client slot.
  typedef struct packed {
    logic        live;
    logic [31:0] real_ip;
    logic [15:0] real_port;
    logic [31:0] node_host;
    logic [15:0] node_port;
    logic [31:0] net;
  } entry_t;

  // Ring control from the sequencer to the cell chain.
  typedef struct packed {
    logic   shift;
    logic   write;
    entry_t wr;
  } ring_ctl_t;

endpackage

>>> design/ictf_cell.sv
// One client slot cell of the rotating table ring.
module ictf_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  ictf_pkg::entry_t d,
  output ictf_pkg::entry_t q
);

  logic        live;
  logic [31:0] real_ip;
  logic [15:0] real_port;
  logic [31:0] node_host;
  logic [15:0] node_port;
  logic [31:0] net;

  // The live flag is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
    end else if (shift) begin
      live <= d.live;
    end
  end

  // Slot contents only move along the ring.
  always_ff @(posedge clk) begin
    if (shift) begin
      real_ip   <= d.real_ip;
      real_port <= d.real_port;
      node_host <= d.node_host;
      node_port <= d.node_port;
      net       <= d.net;
    end
  end

  assign q = '{live: live, real_ip: real_ip, real_port: real_port,
               node_host: node_host, node_port: node_port, net: net};

endmodule

>>> design/ictf_seq.sv
// Sequencer: walks the slot at the head of the ring and builds results.
module ictf_seq #(
  parameter int unsigned TABLE_ENTRIES = ictf_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ictf_pkg::hdr_t     hdr,
  input  logic               hdr_valid,
  output logic               hdr_stall,
  output ictf_pkg::res_t     res,
  output logic               res_valid,
  input  logic               res_stall,
  input  logic [31:0]        network_number,
  input  ictf_pkg::entry_t   head,
  output ictf_pkg::ring_ctl_t ctl
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  ictf_pkg::state_t state, state_next;
  ictf_pkg::hdr_t   item, item_next;
  logic [31:0]      dnet, dnet_next;
  logic             reg_done, reg_done_next;
  logic [IDX_W-1:0] head_idx, head_idx_next;
  logic             pend_valid, pend_valid_next;
  ictf_pkg::res_t   pend, pend_next;
  logic             res_valid_next;
  ictf_pkg::res_t   res_next;

  logic             can_emit;
  logic             end_pos;
  logic             is_reg;
  logic             want_ack;
  logic             free_slot;
  logic             hit;
  logic             match;
  logic             netok;
  logic [2:0]       sf;
  logic [2:0]       df;
  logic [IDX_W-1:0] idx_inc;

  assign can_emit = !res_valid || !res_stall;
  assign end_pos  = (head_idx == IDX_W'(TABLE_ENTRIES - 1));
  assign idx_inc  = end_pos ? '0 : head_idx + 1'b1;
  assign is_reg   = (item.dest_socket == ictf_pkg::ECHO_SOCKET) && (item.dest_host == '0);
  assign hdr_stall = (state != ictf_pkg::S_IDLE);

  // Registration test on the head slot.
  assign free_slot = !head.live;
  assign want_ack  = is_reg && !reg_done &&
                     (free_slot || (head.real_ip == item.src_host &&
                                    head.real_port == item.src_port));

  // Network flags and node match for forwarding.
  assign sf = {item.src_network == ictf_pkg::ALL_ONES32,
               item.src_network == head.net,
               item.src_network == '0};
  assign df = {dnet == ictf_pkg::ALL_ONES32, dnet == head.net, dnet == '0};
  assign netok = df[1] || df[2] || (df[0] && (sf != '0));
  assign match = (item.dest_host == ictf_pkg::ALL_ONES32) ?
                 !(head.node_host == item.src_host && head.node_port == item.src_port &&
                   sf[0]) :
                 (head.node_host == item.dest_host && head.node_port == item.dest_port);
  assign hit = head.live && match && netok;

  // State and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ictf_pkg::S_IDLE;
      head_idx   <= '0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
      reg_done   <= 1'b0;
    end else begin
      state      <= state_next;
      head_idx   <= head_idx_next;
      pend_valid <= pend_valid_next;
      res_valid  <= res_valid_next;
      reg_done   <= reg_done_next;
    end
  end

  always_ff @(posedge clk) begin
    item <= item_next;
    dnet <= dnet_next;
    pend <= pend_next;
    res  <= res_next;
  end

  // Next state, ring control and result words.
  always_comb begin
    state_next      = state;
    item_next       = item;
    dnet_next       = dnet;
    reg_done_next   = reg_done;
    head_idx_next   = head_idx;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    res_valid_next  = res_valid && res_stall;
    res_next        = res;
    ctl             = '0;
    ctl.wr          = head;

    unique case (state)
      ictf_pkg::S_IDLE: begin
        if (hdr_valid) begin
          item_next     = hdr;
          dnet_next     = hdr.dest_network;
          reg_done_next = 1'b0;
          state_next    = ictf_pkg::S_SCAN;
        end
      end

      ictf_pkg::S_SCAN: begin
        if (!want_ack || can_emit) begin
          ctl.shift     = 1'b1;
          head_idx_next = idx_inc;
          // Network patch: the last matching slot in order wins.
          if (item.src_network == '0 && head.live && head.real_ip == item.sender_ip) begin
            dnet_next = head.net;
          end
          if (want_ack) begin
            ctl.write            = 1'b1;
            reg_done_next        = 1'b1;
            res_valid_next       = 1'b1;
            res_next.slot        = 4'(head_idx);
            res_next.last        = 1'b1;
            if (free_slot) begin
              ctl.wr = '{live: 1'b1, real_ip: item.sender_ip,
                         real_port: item.sender_port, node_host: item.sender_ip,
                         node_port: item.sender_port, net: network_number};
              res_next.kind = ictf_pkg::KIND_NEW;
            end else begin
              ctl.wr.real_port = item.sender_port;
              res_next.kind    = ictf_pkg::KIND_RECONNECT;
            end
            res_next.client_ip      = ctl.wr.real_ip;
            res_next.client_port    = ctl.wr.real_port;
            res_next.assigned_host  = ctl.wr.node_host;
            res_next.assigned_port  = ctl.wr.node_port;
            res_next.client_network = ctl.wr.net;
          end
          if (end_pos) begin
            state_next = (reg_done || want_ack) ? ictf_pkg::S_IDLE : ictf_pkg::S_FWD;
          end
        end
      end

      ictf_pkg::S_FWD: begin
        if (!(hit && pend_valid) || can_emit) begin
          ctl.shift     = 1'b1;
          head_idx_next = idx_inc;
          if (hit) begin
            // The held copy is not the final one: send it on.
            if (pend_valid) begin
              res_valid_next = 1'b1;
              res_next       = pend;
            end
            pend_valid_next         = 1'b1;
            pend_next.kind          = ictf_pkg::KIND_FWD;
            pend_next.slot          = 4'(head_idx);
            pend_next.client_ip     = head.real_ip;
            pend_next.client_port   = head.real_port;
            pend_next.assigned_host = '0;
            pend_next.assigned_port = '0;
            pend_next.client_network = head.net;
            pend_next.last          = 1'b0;
          end
          if (end_pos) begin
            state_next = ictf_pkg::S_FLUSH;
          end
        end
      end

      ictf_pkg::S_FLUSH: begin
        if (!pend_valid) begin
          state_next = ictf_pkg::S_IDLE;
        end else if (can_emit) begin
          res_valid_next  = 1'b1;
          res_next        = pend;
          res_next.last   = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = ictf_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = ictf_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> design/ipx_client_table_forwarder.sv
// Top level of the IPX client table forwarder.
// The client table sits in a ring of TABLE_ENTRIES cells that rotates by one slot per cycle
// while a header is scanned and no stalled result holds it, past a single compare unit at its
// head. Each header costs one full turn of the ring for the registration scan and network
// patch, one more turn for the forwarding scan when the header is forwarded, and a flush state
// to release the final copy. Result words leave one per cycle through an output register while
// res_stall is low; hdr_stall is high for the whole time a header is in work.
module ipx_client_table_forwarder #(
  parameter int unsigned TABLE_ENTRIES = ictf_pkg::TABLE_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  ictf_pkg::hdr_t hdr,
  input  logic           hdr_valid,
  output logic           hdr_stall,
  output ictf_pkg::res_t res,
  output logic           res_valid,
  input  logic           res_stall,
  input  logic           network_number_we,
  input  logic [31:0]    network_number
);

  ictf_pkg::entry_t    cell_q [TABLE_ENTRIES];
  ictf_pkg::entry_t    wrap;
  ictf_pkg::ring_ctl_t ctl;
  logic [31:0]         net_reg;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      net_reg <= '0;
    end else if (network_number_we) begin
      net_reg <= network_number;
    end
  end

  // The head slot re-enters the tail, replaced when it is being written.
  assign wrap = ctl.write ? ctl.wr : cell_q[0];

  // Ring of slot cells, moving towards the head.
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    ictf_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ctl.shift),
      .d     ((i == TABLE_ENTRIES - 1) ? wrap : cell_q[(i + 1) % TABLE_ENTRIES]),
      .q     (cell_q[i])
    );
  end

  ictf_seq #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .hdr            (hdr),
    .hdr_valid      (hdr_valid),
    .hdr_stall      (hdr_stall),
    .res            (res),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .network_number (net_reg),
    .head           (cell_q[0]),
    .ctl            (ctl)
  );

endmodule

>>> design/ictf_checker.sv
// Port-level checks of the forwarder, bound to its top level.
module ictf_checker (
  input logic           clk,
  input logic           rst,
  input logic           hdr_valid,
  input logic           hdr_stall,
  input ictf_pkg::res_t res,
  input logic           res_valid,
  input logic           res_stall
);

  // A stalled result word holds.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result word changed while stalled");

  // One header at a time: an accepted header makes the block busy.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && !hdr_stall |=> hdr_stall)
    else $error("header taken while another is in work");

  // An acknowledge is always the only result of its header.
  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind != ictf_pkg::KIND_FWD |-> res.last)
    else $error("acknowledge without last marker");

  // A new registration reports its real address as its assigned node.
  a_new_node: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == ictf_pkg::KIND_NEW |->
      res.client_ip == res.assigned_host && res.client_port == res.assigned_port)
    else $error("new registration with mismatched node");

  // While copies of a header remain, no new header is taken.
  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.last |-> hdr_stall)
    else $error("header accepted before all copies were sent");

endmodule

bind ipx_client_table_forwarder ictf_checker u_ictf_checker (
  .clk       (clk),
  .rst       (rst),
  .hdr_valid (hdr_valid),
  .hdr_stall (hdr_stall),
  .res       (res),
  .res_valid (res_valid),
  .res_stall (res_stall)
);

>>> test/tb_top.sv
// Self-checking testbench for the IPX client table forwarder.
`timescale 1ns / 100ps

module tb_top;

  localparam int NSLOT = 16;
  localparam int TIME_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  ictf_pkg::hdr_t hdr = '0;
  logic hdr_valid = 1'b0;
  logic hdr_stall;
  ictf_pkg::res_t res;
  logic res_valid;
  logic res_stall = 1'b0;
  logic network_number_we = 1'b0;
  logic [31:0] network_number = '0;

  ipx_client_table_forwarder dut (
    .clk(clk), .rst(rst), .hdr(hdr), .hdr_valid(hdr_valid), .hdr_stall(hdr_stall),
    .res(res), .res_valid(res_valid), .res_stall(res_stall),
    .network_number_we(network_number_we), .network_number(network_number)
  );

  always #4 clk = ~clk;

  // Shadow copy of the client table and the configured network.
  logic [31:0] own_net;
  logic        sh_live [NSLOT];
  logic [31:0] sh_ip [NSLOT];
  logic [15:0] sh_port [NSLOT];
  logic [31:0] sh_nhost [NSLOT];
  logic [15:0] sh_nport [NSLOT];
  logic [31:0] sh_net [NSLOT];
  ictf_pkg::res_t expected_words[$];
  int mismatches = 0;
  int cycles = 0;
  bit stall_enable = 1'b1;

  function automatic logic [2:0] net_class(logic [31:0] n, logic [31:0] own);
    return {n == ictf_pkg::ALL_ONES32, n == own, n == 32'd0};
  endfunction

  function automatic ictf_pkg::res_t slot_word(ictf_pkg::kind_t k, int s, bit with_node,
                                               bit fin);
    ictf_pkg::res_t r;
    r.kind = k;
    r.slot = s[3:0];
    r.client_ip = sh_ip[s];
    r.client_port = sh_port[s];
    r.assigned_host = with_node ? sh_nhost[s] : 32'd0;
    r.assigned_port = with_node ? sh_nport[s] : 16'd0;
    r.client_network = sh_net[s];
    r.last = fin;
    return r;
  endfunction

  // Works out the words a header causes and updates the shadow table.
  task automatic predict_header(ictf_pkg::hdr_t h);
    logic [31:0] dnet;
    logic [2:0] sf, df;
    bit matched;
    int picks[$];
    dnet = h.dest_network;
    if (h.src_network == 0) begin
      for (int i = 0; i < NSLOT; i++)
        if (sh_live[i] && sh_ip[i] == h.sender_ip) dnet = sh_net[i];
    end
    if (h.dest_socket == ictf_pkg::ECHO_SOCKET && h.dest_host == 0) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (!sh_live[i]) begin
          sh_live[i] = 1'b1;
          sh_ip[i] = h.sender_ip;
          sh_port[i] = h.sender_port;
          sh_nhost[i] = h.sender_ip;
          sh_nport[i] = h.sender_port;
          sh_net[i] = own_net;
          expected_words.push_back(slot_word(ictf_pkg::KIND_NEW, i, 1, 1));
          return;
        end
        if (sh_ip[i] == h.src_host && sh_port[i] == h.src_port) begin
          sh_port[i] = h.sender_port;
          expected_words.push_back(slot_word(ictf_pkg::KIND_RECONNECT, i, 1, 1));
          return;
        end
      end
    end
    for (int i = 0; i < NSLOT; i++) begin
      if (!sh_live[i]) continue;
      sf = net_class(h.src_network, sh_net[i]);
      df = net_class(dnet, sh_net[i]);
      if (h.dest_host == ictf_pkg::ALL_ONES32)
        matched = !(sh_nhost[i] == h.src_host && sh_nport[i] == h.src_port && sf[0]);
      else
        matched = sh_nhost[i] == h.dest_host && sh_nport[i] == h.dest_port;
      if (matched && (df & ((sf >> 1) | (sf >> 2) | sf | 3'd6)) != 0) picks.push_back(i);
    end
    foreach (picks[k])
      expected_words.push_back(slot_word(ictf_pkg::KIND_FWD, picks[k], 0,
                                         k == picks.size() - 1));
  endtask

  // Sends one header word and predicts its results once accepted.
  task automatic send_header(ictf_pkg::hdr_t h);
    hdr <= h;
    hdr_valid <= 1'b1;
    @(posedge clk);
    while (hdr_stall) @(posedge clk);
    predict_header(h);
    hdr_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random gap between bursts of headers.
  int burst_left = 0;
  task automatic pace;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(0, 6)) @(posedge clk);
    end
    burst_left--;
  endtask

  task automatic drain;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (2 * NSLOT + 8) @(posedge clk);
  endtask

  // The network register is only written once the block has gone quiet.
  task automatic set_network(logic [31:0] v);
    drain();
    network_number <= v;
    network_number_we <= 1'b1;
    @(posedge clk);
    network_number_we <= 1'b0;
    own_net = v;
  endtask

  function automatic ictf_pkg::hdr_t rand_header();
    ictf_pkg::hdr_t h;
    h = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return h;
  endfunction

  function automatic ictf_pkg::hdr_t registration(logic [31:0] ip, logic [15:0] port);
    ictf_pkg::hdr_t h;
    h = rand_header();
    h.dest_host = 32'd0;
    h.dest_socket = ictf_pkg::ECHO_SOCKET;
    h.sender_ip = ip;
    h.sender_port = port;
    return h;
  endfunction

  // Picks a field value: often one of the table's addresses, sometimes an extreme.
  function automatic logic [47:0] pick_node();
    int s;
    s = $urandom_range(0, NSLOT - 1);
    case ($urandom_range(0, 4))
      0: return {$urandom, 16'($urandom)};
      1: return 48'hFFFF_FFFF_FFFF;
      default: return sh_live[s] ? {sh_nhost[s], sh_nport[s]} : {$urandom, 16'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] pick_net();
    int s;
    s = $urandom_range(0, NSLOT - 1);
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return ictf_pkg::ALL_ONES32;
      2: return own_net;
      3: return sh_live[s] ? sh_net[s] : $urandom;
      default: return $urandom;
    endcase
  endfunction

  function automatic ictf_pkg::hdr_t rand_forward();
    ictf_pkg::hdr_t h;
    int s;
    h = rand_header();
    {h.dest_host, h.dest_port} = pick_node();
    {h.src_host, h.src_port} = pick_node();
    h.src_network = pick_net();
    h.dest_network = pick_net();
    s = $urandom_range(0, NSLOT - 1);
    if ($urandom_range(0, 1) && sh_live[s]) h.sender_ip = sh_ip[s];
    if ($urandom_range(0, 3) == 0) h.dest_socket = ictf_pkg::ECHO_SOCKET;
    return h;
  endfunction

  // Directed: registrations, reconnects, extremes and the special cases.
  task automatic test_directed;
    ictf_pkg::hdr_t h;
    set_network(32'd0);
    h = rand_header(); h.dest_host = ictf_pkg::ALL_ONES32; send_header(h);   // empty table
    send_header(registration(32'h0A00_0001, 16'h0000));
    set_network(ictf_pkg::ALL_ONES32);
    send_header(registration(32'hFFFF_FFFF, 16'hFFFF));
    set_network(32'h1234_5678);
    send_header(registration(32'h0000_0000, 16'h1111));
    h = registration(32'h0A00_0009, 16'h2222);
    h.src_host = 32'h0A00_0001; h.src_port = 16'h0000;                  // reconnect of slot 0
    send_header(h);
    h = rand_header(); h.dest_host = ictf_pkg::ALL_ONES32; h.src_network = 0;
    h.sender_ip = 32'hFFFF_FFFF; send_header(h);                       // broadcast, patched net
    h = rand_header(); h.dest_host = ictf_pkg::ALL_ONES32; h.dest_port = 16'hFFFF;
    h.src_host = ictf_pkg::ALL_ONES32; h.src_port = 16'hFFFF; h.src_network = 0;
    h.dest_network = 0; send_header(h);                                 // self exclusion
    h = rand_header(); h.dest_host = 32'h0A00_0001; h.dest_port = 16'h0000;
    h.dest_network = ictf_pkg::ALL_ONES32; send_header(h);              // unicast
    h = rand_header(); h.dest_host = 32'h5555_5555; send_header(h);    // no receiver
    h = '0; send_header(h);
    h = '1; send_header(h);
    drain();
  endtask

  // Sends NSLOT + 2 registrations: they fill the table to the top, and the last ones find no match.
  task automatic test_full_table;
    for (int i = 0; i < NSLOT + 2; i++) begin
      pace();
      send_header(registration($urandom, 16'($urandom)));
    end
    drain();
  endtask

  // Random traffic: mostly well-formed forwards against known clients.
  task automatic test_random(int count);
    ictf_pkg::hdr_t h;
    for (int n = 0; n < count; n++) begin
      pace();
      if (n == count / 2) drain();
      case ($urandom_range(0, 9))
        0: h = registration($urandom, 16'($urandom));
        1: begin
          h = rand_forward();
          h.dest_host = 32'd0;
          h.dest_socket = ictf_pkg::ECHO_SOCKET;
        end
        2: h = rand_header();
        default: h = rand_forward();
      endcase
      send_header(h);
    end
    drain();
  endtask

  initial begin
    own_net = '0;
    foreach (sh_live[i]) sh_live[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_table();
    test_random(180);
    set_network($urandom);
    test_random(200);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Result side stall pattern, with quiet stretches.
  always @(posedge clk) begin
    if (cycles % 2000 < 500) res_stall <= 1'b0;
    else res_stall <= ($urandom_range(0, 3) == 0);
  end

  // Compares each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    ictf_pkg::res_t want;
    cycles <= cycles + 1;
    if (!rst && res_valid && !res_stall) begin
      if (expected_words.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected word %p", res);
      end else begin
        want = expected_words.pop_front();
        if (res !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("mismatch: expected %p, got %p", want, res);
        end
      end
    end
    if (cycles > TIME_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

>>> filelist.f
design/ictf_pkg.sv
design/ictf_cell.sv
design/ictf_seq.sv
design/ipx_client_table_forwarder.sv
design/ictf_checker.sv
test/tb_top.sv
